// File: src/visible_bearing_span_unit_assert.svh
// Assertion macros for the visible bearing span unit.
`ifndef VISIBLE_BEARING_SPAN_UNIT_ASSERT_SVH
`define VISIBLE_BEARING_SPAN_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/vbs_pkg.sv
// Shared widths, angle constants, register codes and arctangent table.
`timescale 1ns / 1ps
`default_nettype none

package vbs_pkg;

	localparam int COORD_W          = 32;
	localparam int ANG_W            = 16;
	localparam int HORIZON_W        = 31;
	localparam int DIFF_W           = COORD_W + 1;
	localparam int SQ_W             = 2 * HORIZON_W;
	localparam int XY_W             = 35;
	localparam int Z_W              = 28;
	localparam int REL_W            = 30;
	localparam int ANG_TABLE_LEN    = 24;
	localparam int ITER_W           = $clog2(ANG_TABLE_LEN);
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 32;
	localparam int HEADING_SHIFT    = 11;

	localparam logic [HORIZON_W-1:0] HORIZON_RESET = HORIZON_W'(655360);

	// Angles inside the arctangent unit are radians in Q.24.
	localparam logic signed [Z_W-1:0]   ANG_HALF_PI = Z_W'(26353589);
	localparam logic signed [REL_W-1:0] ANG_PI      = REL_W'(52707179);
	localparam logic signed [REL_W-1:0] ANG_NEG_PI  = -REL_W'(52707179);
	localparam logic signed [REL_W-1:0] ANG_TWO_PI  = REL_W'(105414357);
	localparam logic signed [REL_W-1:0] ROUND_BIAS  = REL_W'(1024);
	localparam logic signed [REL_W-1:0] OUT_MAX     = REL_W'(32767);
	localparam logic signed [REL_W-1:0] OUT_MIN     = -REL_W'(32768);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROBOT_X   = 2'd0,
		CFG_ROBOT_Y   = 2'd1,
		CFG_HEADING   = 2'd2,
		CFG_HORIZON   = 2'd3
	} cfg_reg_t;

	// atan(2^-i) in Q.24 radians.
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			5'd0:    v = Z_W'(13176795);
			5'd1:    v = Z_W'(7778716);
			5'd2:    v = Z_W'(4110060);
			5'd3:    v = Z_W'(2086331);
			5'd4:    v = Z_W'(1047214);
			5'd5:    v = Z_W'(524117);
			5'd6:    v = Z_W'(262123);
			5'd7:    v = Z_W'(131069);
			5'd8:    v = Z_W'(65536);
			5'd9:    v = Z_W'(32768);
			5'd10:   v = Z_W'(16384);
			5'd11:   v = Z_W'(8192);
			5'd12:   v = Z_W'(4096);
			5'd13:   v = Z_W'(2048);
			5'd14:   v = Z_W'(1024);
			5'd15:   v = Z_W'(512);
			5'd16:   v = Z_W'(256);
			5'd17:   v = Z_W'(128);
			5'd18:   v = Z_W'(64);
			5'd19:   v = Z_W'(32);
			5'd20:   v = Z_W'(16);
			5'd21:   v = Z_W'(8);
			5'd22:   v = Z_W'(4);
			5'd23:   v = Z_W'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: src/vbs_if.sv
// Channel interfaces for target points and span results.
`timescale 1ns / 1ps
`default_nettype none

interface vbs_point_if import vbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic                      last_point;

	modport source (output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink (input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface

interface vbs_span_if import vbs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    any_visible;
	logic signed [ANG_W-1:0] span_min;
	logic signed [ANG_W-1:0] span_max;

	modport source (output valid, output any_visible, output span_min, output span_max,
		input ready);
	modport sink (input valid, input any_visible, input span_min, input span_max,
		output ready);
endinterface

`default_nettype wire

// File: src/visible_bearing_span_unit.sv
// Top level: angular span of target points within the sight horizon.
//
//   channel   direction  transaction carries
//   points    in         point_x, point_y, last_point
//   result    out        any_visible, span_min, span_max (only after a last point)
//   cfg_*     in         write of robot_x, robot_y, robot_heading, horizon limit
//
// A point that is visible passes through ABS, SQX, SQY, HH, CMP, the arctangent iterations,
// REL, RND and FINAL before the next point is accepted; one at the robot position skips the
// iterations and one out of sight goes from CMP straight to FINAL. The steps come from one
// shared 31x31 multiplier used three times and one shifter pair that runs the arctangent
// iterations (at most 24 of them). On a last point the unit waits in its final step while an
// earlier result is still not taken. Reset is asynchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module visible_bearing_span_unit import vbs_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	vbs_point_if.sink             points,
	vbs_span_if.source            result
);

	localparam int NITER = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_STEPS;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(NITER - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ABS, ST_SQX, ST_SQY, ST_HH, ST_CMP, ST_ITER, ST_REL, ST_RND, ST_FINAL
	} state_t;

	state_t state_q;

	logic signed [COORD_W-1:0] robot_x_q;
	logic signed [COORD_W-1:0] robot_y_q;
	logic signed [ANG_W-1:0]   heading_q;
	logic [HORIZON_W-1:0]      horizon_q;

	logic signed [DIFF_W-1:0]  dx_q;
	logic signed [DIFF_W-1:0]  dy_q;
	logic                      last_q;
	logic [HORIZON_W-1:0]      ax_q;
	logic [HORIZON_W-1:0]      ay_q;
	logic                      in_range_q;
	logic [SQ_W-1:0]           prod_q;
	logic [SQ_W:0]             acc_q;
	logic signed [XY_W-1:0]    x_q;
	logic signed [XY_W-1:0]    y_q;
	logic signed [Z_W-1:0]     z_q;
	logic [ITER_W-1:0]         iter_q;
	logic signed [REL_W-1:0]   rel_q;

	logic signed [ANG_W-1:0]   run_min_q;
	logic signed [ANG_W-1:0]   run_max_q;
	logic                      seen_q;
	logic                      out_valid_q;
	logic                      out_vis_q;
	logic signed [ANG_W-1:0]   out_min_q;
	logic signed [ANG_W-1:0]   out_max_q;

	logic                      in_acc;
	logic                      emit_span;
	logic [DIFF_W-1:0]         abs_x;
	logic [DIFF_W-1:0]         abs_y;
	logic [HORIZON_W-1:0]      mul_a;
	logic [SQ_W-1:0]           mul_p;
	logic                      visible;
	logic                      zero_off;
	logic signed [XY_W-1:0]    xe;
	logic signed [XY_W-1:0]    ye;
	logic signed [XY_W-1:0]    xs;
	logic signed [XY_W-1:0]    ys;
	logic signed [REL_W-1:0]   head_ang;
	logic signed [REL_W-1:0]   rel_raw;
	logic signed [REL_W-1:0]   rnd;
	logic signed [REL_W-1:0]   q_full;
	logic signed [ANG_W-1:0]   q_sat;

	assign points.ready       = (state_q == ST_IDLE);
	assign in_acc             = points.valid && points.ready;
	assign result.valid       = out_valid_q;
	assign result.any_visible = out_vis_q;
	assign result.span_min    = out_min_q;
	assign result.span_max    = out_max_q;

	// A last point loads the result register once the previous transaction has left it.
	assign emit_span = (state_q == ST_FINAL) && last_q && (!out_valid_q || result.ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_x_q <= '0;
			robot_y_q <= '0;
			heading_q <= '0;
			horizon_q <= HORIZON_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ROBOT_X: robot_x_q <= $signed(cfg_wdata[COORD_W-1:0]);
				CFG_ROBOT_Y: robot_y_q <= $signed(cfg_wdata[COORD_W-1:0]);
				CFG_HEADING: heading_q <= $signed(cfg_wdata[ANG_W-1:0]);
				CFG_HORIZON: horizon_q <= cfg_wdata[HORIZON_W-1:0];
			endcase
		end
	end

	always_comb begin
		abs_x = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
		abs_y = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
	end

	// The one multiplier squares |dx|, then |dy|, then the horizon.
	always_comb begin
		unique case (state_q)
			ST_SQX:  mul_a = ax_q;
			ST_SQY:  mul_a = ay_q;
			default: mul_a = horizon_q;
		endcase
		mul_p = SQ_W'(mul_a) * SQ_W'(mul_a);
	end

	assign visible  = in_range_q && (acc_q <= {1'b0, prod_q});
	assign zero_off = (dx_q == '0) && (dy_q == '0);
	assign xe       = XY_W'(dx_q);
	assign ye       = XY_W'(dy_q);
	assign xs       = x_q >>> iter_q;
	assign ys       = y_q >>> iter_q;

	always_comb begin
		head_ang = REL_W'(heading_q) <<< HEADING_SHIFT;
		rel_raw  = REL_W'(z_q) - head_ang;
		rnd      = rel_q + ROUND_BIAS;
		q_full   = rnd >>> HEADING_SHIFT;
		priority if (q_full > OUT_MAX) begin
			q_sat = OUT_MAX[ANG_W-1:0];
		end else if (q_full < OUT_MIN) begin
			q_sat = OUT_MIN[ANG_W-1:0];
		end else begin
			q_sat = q_full[ANG_W-1:0];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					dx_q   <= DIFF_W'(points.point_x) - DIFF_W'(robot_x_q);
					dy_q   <= DIFF_W'(points.point_y) - DIFF_W'(robot_y_q);
					last_q <= points.last_point;
				end
			end
			ST_ABS: begin
				ax_q       <= abs_x[HORIZON_W-1:0];
				ay_q       <= abs_y[HORIZON_W-1:0];
				in_range_q <= (abs_x <= DIFF_W'(horizon_q)) && (abs_y <= DIFF_W'(horizon_q));
			end
			ST_SQX: prod_q <= mul_p;
			ST_SQY: begin
				prod_q <= mul_p;
				acc_q  <= {1'b0, prod_q};
			end
			ST_HH: begin
				prod_q <= mul_p;
				acc_q  <= acc_q + {1'b0, prod_q};
			end
			ST_CMP: begin
				iter_q <= '0;
				// Turn a vector in the left half plane by a quarter turn first.
				priority if (zero_off || !xe[XY_W-1]) begin
					x_q <= xe;
					y_q <= ye;
					z_q <= '0;
				end else if (!ye[XY_W-1]) begin
					x_q <= ye;
					y_q <= -xe;
					z_q <= ANG_HALF_PI;
				end else begin
					x_q <= -ye;
					y_q <= xe;
					z_q <= -ANG_HALF_PI;
				end
			end
			ST_ITER: begin
				iter_q <= iter_q + 1'b1;
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_entry(iter_q);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_entry(iter_q);
				end
			end
			ST_REL: begin
				priority if (rel_raw > ANG_PI) begin
					rel_q <= rel_raw - ANG_TWO_PI;
				end else if (rel_raw < ANG_NEG_PI) begin
					rel_q <= rel_raw + ANG_TWO_PI;
				end else begin
					rel_q <= rel_raw;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, running span and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_min_q   <= '0;
			run_max_q   <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_vis_q   <= 1'b0;
			out_min_q   <= '0;
			out_max_q   <= '0;
		end else begin
			if (emit_span) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_ABS;
					end
				end
				ST_ABS: state_q <= ST_SQX;
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_HH;
				ST_HH:  state_q <= ST_CMP;
				ST_CMP: begin
					priority if (!visible) begin
						state_q <= ST_FINAL;
					end else if (zero_off) begin
						state_q <= ST_REL;
					end else begin
						state_q <= ST_ITER;
					end
				end
				ST_ITER: begin
					if (iter_q == ITER_LAST) begin
						state_q <= ST_REL;
					end
				end
				ST_REL: state_q <= ST_RND;
				ST_RND: begin
					state_q <= ST_FINAL;
					seen_q  <= 1'b1;
					if (!seen_q || (q_sat < run_min_q)) begin
						run_min_q <= q_sat;
					end
					if (!seen_q || (q_sat > run_max_q)) begin
						run_max_q <= q_sat;
					end
				end
				ST_FINAL: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (emit_span) begin
						out_vis_q   <= seen_q;
						out_min_q   <= seen_q ? run_min_q : '0;
						out_max_q   <= seen_q ? run_max_q : '0;
						run_min_q   <= '0;
						run_max_q   <= '0;
						seen_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "visible_bearing_span_unit_assert.svh"

	`VBS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !points.ready, "ready after accept")
	`VBS_ASSERT_SAME(a_empty_span_zero, clk, arst_n, result.valid && !result.any_visible, (result.span_min == '0) && (result.span_max == '0), "empty set with nonzero span")
	`VBS_ASSERT_SAME(a_span_ordered, clk, arst_n, seen_q, run_min_q <= run_max_q, "running minimum above maximum")
	`VBS_ASSERT_SAME(a_iter_bound, clk, arst_n, state_q == ST_ITER, iter_q <= ITER_LAST, "iteration count overrun")

endmodule

`default_nettype wire

// File: tb/vbs_span_checker.sv
// Checker for the visible bearing span unit: mirrors the registers, predicts and compares spans.
`timescale 1ns / 1ps

module vbs_span_checker import vbs_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	vbs_point_if                  points,
	vbs_span_if                   result,
	output int unsigned           mismatches,
	output int unsigned           pending,
	output int unsigned           spans_seen,
	output int unsigned           lit_points
);

	typedef struct packed {
		logic                    any_visible;
		logic signed [ANG_W-1:0] span_min;
		logic signed [ANG_W-1:0] span_max;
	} span_t;

	// Angles in Q.24 radians.
	localparam longint HALF_PI_Q24     = 64'sd26353589;
	localparam longint PI_Q24          = 64'sd52707179;
	localparam longint TWO_PI_Q24      = 64'sd105414357;
	localparam int     ARCTAN_ENTRIES  = 24;
	localparam longint DEFAULT_HORIZON = 64'sd655360;

	localparam longint ARCTAN_Q24 [ARCTAN_ENTRIES] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117,
		262123, 131069, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128,
		64, 32, 16, 8, 4, 2
	};

	longint robot_x_m, robot_y_m, heading_m, horizon_m;
	longint low_bearing, high_bearing;
	logic   any_lit;
	span_t  span_q [$];
	int unsigned n_bad, n_spans, n_lit;

	// Vectoring rotation toward the positive x axis; the accumulated angle is the bearing.
	function automatic longint bearing_q24(longint x, longint y);
		longint z, t, xs, ys;
		int i;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HALF_PI_Q24;
			end else begin
				t = x; x = -y; y = t; z = -HALF_PI_Q24;
			end
		end
		for (i = 0; i < CORDIC_STEPS && i < ARCTAN_ENTRIES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z = z + ARCTAN_Q24[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ARCTAN_Q24[i];
			end
		end
		return z;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		span_t  got, want;
		longint dx, dy, ax, ay, rel, q;
		logic   lit;
		if (!arst_n) begin
			robot_x_m    = 0;
			robot_y_m    = 0;
			heading_m    = 0;
			horizon_m    = DEFAULT_HORIZON;
			low_bearing  = 0;
			high_bearing = 0;
			any_lit      = 1'b0;
			span_q.delete();
			n_bad        = 0;
			n_spans      = 0;
			n_lit        = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_ROBOT_X: robot_x_m = longint'($signed(cfg_wdata));
					CFG_ROBOT_Y: robot_y_m = longint'($signed(cfg_wdata));
					CFG_HEADING: heading_m = longint'($signed(cfg_wdata[ANG_W-1:0]));
					CFG_HORIZON: horizon_m = longint'({1'b0, cfg_wdata[HORIZON_W-1:0]});
					default: ;
				endcase
			end

			// Results are checked before points so a span cannot match its own trigger.
			if (result.valid && result.ready) begin
				got.any_visible = result.any_visible;
				got.span_min    = result.span_min;
				got.span_max    = result.span_max;
				n_spans++;
				if (span_q.size() == 0) begin
					$display("%0t ns: span result with none expected: visible=%0b min=%0d max=%0d",
						$time, got.any_visible, got.span_min, got.span_max);
					n_bad++;
				end else begin
					want = span_q.pop_front();
					if (got.any_visible !== want.any_visible || got.span_min !== want.span_min ||
							got.span_max !== want.span_max) begin
						$display("%0t ns: span mismatch: expected visible=%0b min=%0d max=%0d, got visible=%0b min=%0d max=%0d",
							$time, want.any_visible, want.span_min, want.span_max,
							got.any_visible, got.span_min, got.span_max);
						n_bad++;
					end
				end
			end

			if (points.valid && points.ready) begin
				dx  = longint'($signed(points.point_x)) - robot_x_m;
				dy  = longint'($signed(points.point_y)) - robot_y_m;
				ax  = (dx < 0) ? -dx : dx;
				ay  = (dy < 0) ? -dy : dy;
				lit = 1'b0;
				if (ax <= horizon_m && ay <= horizon_m)
					lit = (ax * ax + ay * ay) <= horizon_m * horizon_m;
				if (lit) begin
					n_lit++;
					rel = bearing_q24(dx, dy) - heading_m * 2048;
					if (rel > PI_Q24)
						rel = rel - TWO_PI_Q24;
					else if (rel < -PI_Q24)
						rel = rel + TWO_PI_Q24;
					q = (rel + 1024) >>> 11;
					if (q > 32767)
						q = 32767;
					if (q < -32768)
						q = -32768;
					if (!any_lit) begin
						low_bearing  = q;
						high_bearing = q;
						any_lit      = 1'b1;
					end else begin
						if (q < low_bearing)
							low_bearing = q;
						if (q > high_bearing)
							high_bearing = q;
					end
				end
				if (points.last_point) begin
					want.any_visible = any_lit;
					want.span_min    = any_lit ? low_bearing[ANG_W-1:0] : '0;
					want.span_max    = any_lit ? high_bearing[ANG_W-1:0] : '0;
					span_q = {span_q, want};
					low_bearing  = 0;
					high_bearing = 0;
					any_lit      = 1'b0;
				end
			end
		end
		mismatches <= n_bad;
		pending    <= span_q.size();
		spans_seen <= n_spans;
		lit_points <= n_lit;
	end

endmodule

// File: tb/tb_visible_bearing_span_unit.sv
// Testbench top: clock, reset, register loads, point and ready traffic, and the verdict.
`timescale 1ns / 1ps

module tb_visible_bearing_span_unit;
	import vbs_pkg::*;

	localparam int STEPS           = CORDIC_STEPS_DEF;
	localparam int RANDOM_PHASES   = 6;
	localparam int POINTS_PER_PHASE = 75;
	localparam int SQUEEZE_CYCLES  = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int unsigned mismatches, pending, spans_seen, lit_points;
	int unsigned points_sent = 0;
	int unsigned loads = 0;
	bit          squeeze_req = 1'b0;
	bit          squeeze_done = 1'b0;
	bit          steady = 1'b0;

	logic [31:0] cur_rx = '0;
	logic [31:0] cur_ry = '0;
	logic [30:0] cur_hz = 31'd655360;

	vbs_point_if pt_ch ();
	vbs_span_if  span_ch ();

	visible_bearing_span_unit #(.CORDIC_STEPS(STEPS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.points    (pt_ch),
		.result    (span_ch)
	);

	vbs_span_checker #(.CORDIC_STEPS(STEPS)) span_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.points     (pt_ch),
		.result     (span_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.spans_seen (spans_seen),
		.lit_points (lit_points)
	);

	always #6 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offset of up to a little beyond the horizon, either sign.
	function automatic logic [31:0] near(logic [31:0] base);
		longint reach, m;
		reach = longint'(cur_hz) + longint'(cur_hz) / 8 + 1;
		m = longint'({$urandom, $urandom} >> 1) % (reach + 1);
		if ($urandom_range(0, 1))
			m = -m;
		return base + m[31:0];
	endfunction

	task automatic pick_point(output logic [31:0] x, output logic [31:0] y);
		int r;
		logic [31:0] hv;
		r  = $urandom_range(0, 99);
		hv = {1'b0, cur_hz};
		if (r < 70) begin
			x = near(cur_rx);
			y = near(cur_ry);
		end else if (r < 80) begin
			x = cur_rx;
			y = cur_ry;
			if ($urandom_range(0, 1))
				x = $urandom_range(0, 1) ? cur_rx + hv : cur_rx - hv;
			else
				y = $urandom_range(0, 1) ? cur_ry + hv : cur_ry - hv;
		end else if (r < 86) begin
			x = cur_rx;
			y = cur_ry;
		end else begin
			x = $urandom;
			y = $urandom;
		end
	endtask

	// Writes all four registers on consecutive cycles; upper unused bits get random values.
	task automatic load_config(input logic [31:0] rx, input logic [31:0] ry,
			input logic [15:0] hd, input logic [30:0] hz);
		cfg_reg_t              idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		idx[0] = CFG_ROBOT_X; val[0] = rx;
		idx[1] = CFG_ROBOT_Y; val[1] = ry;
		idx[2] = CFG_HEADING; val[2] = {16'($urandom), hd};
		idx[3] = CFG_HORIZON; val[3] = {1'($urandom), hz};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_rx = rx;
		cur_ry = ry;
		cur_hz = hz;
		loads++;
	endtask

	task automatic offer_point(input logic [31:0] x, input logic [31:0] y, input logic last);
		pt_ch.valid      <= 1'b1;
		pt_ch.point_x    <= x;
		pt_ch.point_y    <= y;
		pt_ch.last_point <= last;
		do
			@(posedge clk);
		while (!pt_ch.ready);
		points_sent++;
	endtask

	task automatic idle_points();
		int n;
		n = steady ? 0 : pick_gap();
		if (n > 0) begin
			pt_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_directed(input logic [31:0] x, input logic [31:0] y, input logic last);
		offer_point(x, y, last);
		idle_points();
	endtask

	// Waits for every span to arrive, then lets a point still in flight finish.
	task automatic drain();
		pt_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (STEPS + 12) @(posedge clk);
	endtask

	// Result side: random stalls, one long hold-off on request, and some stall-free stretches.
	initial begin
		int n;
		span_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				span_ch.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze_done = 1'b1;
			end
			span_ch.ready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat (100) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
			n = pick_gap();
			if (n > 0) begin
				span_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		int          p, k, set_len, sent_here;
		logic [31:0] px, py;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_ROBOT_X;
		cfg_wdata        <= '0;
		pt_ch.valid      <= 1'b0;
		pt_ch.point_x    <= '0;
		pt_ch.point_y    <= '0;
		pt_ch.last_point <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets under the reset registers: robot at origin, heading 0, 10 m horizon.
		send_directed(32'd0, 32'd0, 1'b1);                    // point at the robot
		send_directed(32'd1310720, 32'd0, 1'b1);              // nothing visible
		send_directed(32'd655360, 32'd0, 1'b0);               // on the horizon, four axes
		send_directed(32'd0, 32'd655360, 1'b0);
		send_directed(-32'sd655360, 32'd0, 1'b0);
		send_directed(32'd0, -32'sd655360, 1'b0);
		send_directed(32'd393216, 32'd524288, 1'b1);          // 6-8-10 triangle, on the horizon
		send_directed(-32'sd393216, -32'sd524288, 1'b0);
		send_directed(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_directed(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_directed(-32'sd1, 32'd0, 1'b0);                  // just behind, bearing near pi
		send_directed(-32'sd65536, -32'sd1, 1'b1);
		send_directed(32'd655361, 32'd0, 1'b1);               // just past the horizon
		send_directed(32'd463410, 32'd463410, 1'b0);          // diagonal just outside
		send_directed(32'd463409, 32'd463409, 1'b1);          // diagonal just inside
		send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			case (p)
				0: load_config(32'd98304, -32'sd147456, 16'sd12868, 31'd327680);
				1: load_config(32'h7FFF_FFFF, 32'h8000_0000, 16'sd25736, 31'h7FFF_FFFF);
				2: load_config($urandom, $urandom, -16'sd25736, 31'd0);
				3: load_config(32'd0, 32'd0, 16'h8000, 31'd6553600);
				4: load_config($urandom, $urandom, 16'h7FFF, 31'($urandom_range(1, 1 << 22)));
				default: load_config(32'h8000_0000, 32'h7FFF_FFFF, 16'($urandom), 31'($urandom));
			endcase
			steady = (p == 3);
			// The first random phase runs while the result side is held off.
			if (p == 0)
				squeeze_req = 1'b1;
			sent_here = 0;
			while (sent_here < POINTS_PER_PHASE) begin
				set_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 7);
				for (k = 0; k < set_len; k++) begin
					pick_point(px, py);
					offer_point(px, py, k == set_len - 1);
					sent_here++;
					idle_points();
				end
			end
		end
		drain();

		$display("Ran %0d points through %0d register settings; %0d were within sight.",
			points_sent, loads + 1, lit_points);
		$display("Checked %0d span results, one long result hold-off included.", spans_seen);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(64'd10_000_000);
		$display("Timeout with %0d span results still outstanding.", pending);
		$display("status: fail");
		$finish;
	end

endmodule
